>>> rtl/rsf_pkg.sv
package rsf_pkg;

   localparam int VALUE_W    = 96;
   localparam int LEN_W      = 5;
   localparam int TIME_W     = 32;
   localparam int WINDOW_W   = 16;
   localparam int NIBBLE_NUM = VALUE_W / 4;

   // longest identifier kept; longer counts are clipped to this
   localparam logic [LEN_W-1:0] MAX_ID_NIBBLES = LEN_W'(24);

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // register index, taken from the word address bits of paddr
   localparam logic [CSR_ADDR_W-3:0] CSR_WINDOW_INDEX = '0;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(180);

   typedef struct packed {
      logic [LEN_W-1:0]   len;
      logic [VALUE_W-1:0] value;
      logic [TIME_W-1:0]  stamp;
   } entry_type;

endpackage

>>> rtl/rsf_table.sv
module rsf_table #(
   parameter int ENTRIES = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  rsf_pkg::entry_type         wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output rsf_pkg::entry_type         rd_data
);

   rsf_pkg::entry_type mem_ff [ENTRIES];
   rsf_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/rsf_csr.sv
module rsf_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rsf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rsf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rsf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output logic [rsf_pkg::WINDOW_W-1:0]     window
);

   logic [rsf_pkg::WINDOW_W-1:0] window_ff;
   logic [rsf_pkg::WINDOW_W-1:0] window_in;
   logic                         sel_window;

   assign sel_window = (csr_paddr[rsf_pkg::CSR_ADDR_W-1:2] == rsf_pkg::CSR_WINDOW_INDEX);

   always_comb begin
      window_in = window_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_window) begin
         window_in = csr_pwdata[rsf_pkg::WINDOW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= rsf_pkg::WINDOW_RESET;
      end else begin
         window_ff <= window_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (sel_window) begin
         csr_prdata = rsf_pkg::CSR_DATA_W'(window_ff);
      end
   end

   assign csr_pready = 1'b1;
   assign window     = window_ff;

endmodule

>>> rtl/rsf_ctrl.sv
module rsf_ctrl #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [63:0]                       req_id_low,
   input  logic [31:0]                       req_id_high,
   input  logic [rsf_pkg::LEN_W-1:0]         req_id_nibbles,
   input  logic [rsf_pkg::TIME_W-1:0]        req_timestamp_seconds,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_is_repeat,
   input  logic [rsf_pkg::WINDOW_W-1:0]      window,
   output logic                              wr_en,
   output logic [$clog2(TABLE_ENTRIES)-1:0]  wr_addr,
   output rsf_pkg::entry_type                wr_data,
   output logic                              rd_en,
   output logic [$clog2(TABLE_ENTRIES)-1:0]  rd_addr,
   input  rsf_pkg::entry_type                rd_data
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [CNT_W-1:0] FULL     = CNT_W'(TABLE_ENTRIES);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MATCH  = 3'd1;
   localparam logic [2:0] ST_OLDEST = 3'd2;
   localparam logic [2:0] ST_WRITE  = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              filled_ff, filled_in;
   logic [CNT_W-1:0]              iss_ff, iss_in;
   logic                          chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]              chk_idx_ff, chk_idx_in;
   logic [rsf_pkg::TIME_W-1:0]    min_time_ff, min_time_in;
   logic [IDX_W-1:0]              min_idx_ff, min_idx_in;
   logic [IDX_W-1:0]              slot_ff, slot_in;
   logic                          grow_ff, grow_in;
   logic                          rep_ff, rep_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_repeat_ff, rsp_repeat_in;
   rsf_pkg::entry_type            key_ff, key_in;

   logic                          accept;
   logic [rsf_pkg::LEN_W-1:0]     digits;
   logic [rsf_pkg::VALUE_W-1:0]   raw_value;
   logic [rsf_pkg::VALUE_W-1:0]   value_mask;
   logic [CNT_W-1:0]              iss_limit;
   logic                          hit;
   logic                          last_match;
   logic [rsf_pkg::TIME_W-1:0]    delta;
   logic                          rep_calc;
   logic                          take;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign digits    = (req_id_nibbles > rsf_pkg::MAX_ID_NIBBLES) ?
                      rsf_pkg::MAX_ID_NIBBLES : req_id_nibbles;
   assign raw_value = {req_id_high, req_id_low};

   // stray digits above the count are dropped
   always_comb begin
      for (int j = 0; j < rsf_pkg::NIBBLE_NUM; j++) begin
         value_mask[4*j +: 4] = (rsf_pkg::LEN_W'(j) < digits) ? 4'hf : 4'h0;
      end
   end

   assign iss_limit = (state_ff == ST_MATCH) ? filled_ff : FULL;
   assign rd_en     = ((state_ff == ST_MATCH) || (state_ff == ST_OLDEST)) &&
                      (iss_ff < iss_limit);
   assign rd_addr   = iss_ff[IDX_W-1:0];

   assign hit        = (rd_data.len == key_ff.len) && (rd_data.value == key_ff.value);
   assign last_match = ((CNT_W'(chk_idx_ff) + CNT_W'(1)) == filled_ff);
   assign delta      = key_ff.stamp - rd_data.stamp;
   // a clock that went backwards counts as a repeat
   assign rep_calc   = delta[rsf_pkg::TIME_W-1] ||
                       (delta <= rsf_pkg::TIME_W'(window));
   assign take       = (chk_idx_ff == '0) || (rd_data.stamp < min_time_ff);

   always_comb begin
      state_in      = state_ff;
      filled_in     = filled_ff;
      iss_in        = iss_ff;
      chk_valid_in  = rd_en;
      chk_idx_in    = iss_ff[IDX_W-1:0];
      min_time_in   = min_time_ff;
      min_idx_in    = min_idx_ff;
      slot_in       = slot_ff;
      grow_in       = grow_ff;
      rep_in        = rep_ff;
      key_in        = key_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_repeat_in = rsp_repeat_ff;
      wr_en         = 1'b0;

      if (rd_en) begin
         iss_in = iss_ff + CNT_W'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in.len   = digits;
               key_in.value = raw_value & value_mask;
               key_in.stamp = req_timestamp_seconds;
               iss_in       = '0;
               rep_in       = 1'b0;
               if (req_id_nibbles == '0) begin
                  state_in = ST_DONE;
               end else if (filled_ff == '0) begin
                  slot_in  = '0;
                  grow_in  = 1'b1;
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_MATCH;
               end
            end
         end
         ST_MATCH: begin
            if (chk_valid_ff) begin
               if (hit) begin
                  slot_in  = chk_idx_ff;
                  grow_in  = 1'b0;
                  rep_in   = rep_calc;
                  state_in = ST_WRITE;
               end else if (last_match) begin
                  if (filled_ff < FULL) begin
                     slot_in  = filled_ff[IDX_W-1:0];
                     grow_in  = 1'b1;
                     state_in = ST_WRITE;
                  end else begin
                     iss_in   = '0;
                     state_in = ST_OLDEST;
                  end
               end
            end
         end
         ST_OLDEST: begin
            if (chk_valid_ff) begin
               if (take) begin
                  min_time_in = rd_data.stamp;
                  min_idx_in  = chk_idx_ff;
               end
               if (chk_idx_ff == LAST_IDX) begin
                  slot_in  = take ? chk_idx_ff : min_idx_ff;
                  grow_in  = 1'b0;
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            wr_en = 1'b1;
            if (grow_ff) begin
               filled_in = filled_ff + CNT_W'(1);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_repeat_in = rep_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         filled_ff    <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filled_ff    <= filled_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_ff        <= iss_in;
      chk_idx_ff    <= chk_idx_in;
      min_time_ff   <= min_time_in;
      min_idx_ff    <= min_idx_in;
      slot_ff       <= slot_in;
      grow_ff       <= grow_in;
      rep_ff        <= rep_in;
      key_ff        <= key_in;
      rsp_repeat_ff <= rsp_repeat_in;
   end

   assign wr_addr       = slot_ff;
   assign wr_data       = key_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_is_repeat = rsp_repeat_ff;

   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= FULL)
      else $error("fill count beyond table size");

   a_filled_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(filled_ff)) |->
         (filled_ff == $past(filled_ff) + CNT_W'(1)) && $past(state_ff == ST_WRITE))
      else $error("fill count moved other than by one write");

   a_scan_in_fill: assert property (@(posedge clock) disable iff (reset)
      (chk_valid_ff && (state_ff == ST_MATCH)) |-> (CNT_W'(chk_idx_ff) < filled_ff))
      else $error("match scan read an unfilled entry");

   a_empty_id: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_id_nibbles == '0)) |=> ((state_ff == ST_DONE) && !rep_ff))
      else $error("empty identifier did not bypass the table");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(state_ff == ST_DONE))
      else $error("result word raised outside the done state");

endmodule

>>> rtl/repeat_sighting_filter.sv
// channel  direction  handshake              payload
// req      in         req_valid / req_stall  id_low, id_high, id_nibbles, timestamp_seconds
// rsp      out        rsp_valid / rsp_stall  is_repeat
// csr      in/out     apb write/read         repeat_window_seconds at byte address 0
//
// a word skips the table when id_nibbles is zero; otherwise it is matched against the filled
// entries and written, and a full table with no hit is first scanned for the oldest entry:
// one table read per cycle from the single read port sets the length of both scans.
// reset clears the fill count and handshake state; table contents stay unknown and are
// never read before they are written.
// a stalled result sits in the output register while the next word is taken in.
module repeat_sighting_filter #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [63:0]                      req_id_low,
   input  logic [31:0]                      req_id_high,
   input  logic [4:0]                       req_id_nibbles,
   input  logic [31:0]                      req_timestamp_seconds,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_is_repeat,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rsf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rsf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rsf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   logic [rsf_pkg::WINDOW_W-1:0] window;
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   rsf_pkg::entry_type           wr_data;
   logic                         rd_en;
   logic [IDX_W-1:0]             rd_addr;
   rsf_pkg::entry_type           rd_data;

   rsf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .window      (window)
   );

   rsf_table #(
      .ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rsf_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_ctrl (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_id_low            (req_id_low),
      .req_id_high           (req_id_high),
      .req_id_nibbles        (req_id_nibbles),
      .req_timestamp_seconds (req_timestamp_seconds),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_is_repeat         (rsp_is_repeat),
      .window                (window),
      .wr_en                 (wr_en),
      .wr_addr               (wr_addr),
      .wr_data               (wr_data),
      .rd_en                 (rd_en),
      .rd_addr               (rd_addr),
      .rd_data               (rd_data)
   );

endmodule
